// ===== sv/mtep_pkg.sv =====
// ============================================================================
// mtep_pkg: shared types and constants of the MIDI track event parser
// Parser phases, result status codes, the result record and the
// data length lookup by event kind.
// ============================================================================
package mtep_pkg;

   localparam logic [7:0] TOP_BIT     = 8'h80;
   localparam int         DELTA_WIDTH = 28;

   typedef enum logic [2:0] {
      PH_DELTA  = 3'd0,
      PH_STATUS = 3'd1,
      PH_DATA1  = 3'd2,
      PH_DATA2  = 3'd3,
      PH_SKIP   = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_DELTA_LONG = 2'd1,
      ST_NO_RUNNING = 2'd2
   } status_type;

   localparam logic [2:0] KIND_META = 3'd7;

   typedef struct packed {
      logic [DELTA_WIDTH-1:0] delta_ticks;
      logic [2:0]             event_kind;
      logic [3:0]             channel;
      logic [7:0]             first_data;
      logic [7:0]             second_data;
      logic [1:0]             parse_status;
   } result_type;

   // Number of data bytes that follow a status byte of the given kind
   function automatic logic [1:0] data_length(input logic [2:0] kind);
      logic [1:0] len;
      case (kind)
         3'd4, 3'd5: len = 2'd1;
         default:    len = 2'd2;
      endcase
      return len;
   endfunction

endpackage

// ===== sv/mtep_core.sv =====
// ============================================================================
// mtep_core: byte-wise track parser state
// Holds the phase, delta accumulator and running status, and forms at
// most one result per accepted byte.
// ============================================================================
module mtep_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           track_byte,
   output logic                 res_valid,
   output mtep_pkg::result_type res
);

   mtep_pkg::phase_type phase_ff, phase_in;
   logic [mtep_pkg::DELTA_WIDTH-1:0] delta_accum_ff, delta_accum_in;
   logic [1:0] delta_count_ff, delta_count_in;
   logic [2:0] run_kind_ff, run_kind_in;
   logic [3:0] run_channel_ff, run_channel_in;
   logic [1:0] run_length_ff, run_length_in;
   logic       run_valid_ff, run_valid_in;
   logic [7:0] held_first_ff, held_first_in;
   logic [7:0] skip_left_ff, skip_left_in;
   logic [7:0] skip_dec;

   logic top_set;
   assign top_set  = (track_byte & mtep_pkg::TOP_BIT) != 8'd0;
   assign skip_dec = skip_left_ff - 8'd1;

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         mtep_pkg::PH_STATUS: begin
            if (top_set) begin
               phase_in = mtep_pkg::PH_DATA1;
            end else if (!run_valid_ff || run_length_ff == 2'd1) begin
               phase_in = mtep_pkg::PH_DELTA;
            end else begin
               phase_in = mtep_pkg::PH_DATA2;
            end
         end
         mtep_pkg::PH_DATA1: begin
            phase_in = (run_length_ff == 2'd1) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_DATA2;
         end
         mtep_pkg::PH_DATA2: begin
            if (run_kind_ff == mtep_pkg::KIND_META && track_byte != 8'd0) begin
               phase_in = mtep_pkg::PH_SKIP;
            end else begin
               phase_in = mtep_pkg::PH_DELTA;
            end
         end
         mtep_pkg::PH_SKIP: begin
            phase_in = (skip_dec == 8'd0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
         end
         default: begin
            if (delta_count_ff == 2'd3 && top_set) begin
               phase_in = mtep_pkg::PH_DELTA;
            end else begin
               phase_in = top_set ? mtep_pkg::PH_DELTA : mtep_pkg::PH_STATUS;
            end
         end
      endcase
   end

   // Datapath and result
   always_comb begin
      delta_accum_in = delta_accum_ff;
      delta_count_in = delta_count_ff;
      run_kind_in    = run_kind_ff;
      run_channel_in = run_channel_ff;
      run_length_in  = run_length_ff;
      run_valid_in   = run_valid_ff;
      held_first_in  = held_first_ff;
      skip_left_in   = skip_left_ff;
      res_valid      = 1'b0;
      res            = '0;
      case (phase_ff)
         mtep_pkg::PH_STATUS: begin
            if (top_set) begin
               run_kind_in    = track_byte[6:4];
               run_channel_in = track_byte[3:0];
               run_length_in  = mtep_pkg::data_length(track_byte[6:4]);
               run_valid_in   = 1'b1;
            end else if (!run_valid_ff) begin
               res_valid        = 1'b1;
               res.delta_ticks  = delta_accum_ff;
               res.first_data   = track_byte;
               res.parse_status = mtep_pkg::ST_NO_RUNNING;
               delta_accum_in   = '0;
               delta_count_in   = 2'd0;
            end else begin
               // running status: this byte is the first data byte
               held_first_in = track_byte;
               if (run_length_ff == 2'd1) begin
                  res_valid        = 1'b1;
                  res.delta_ticks  = delta_accum_ff;
                  res.event_kind   = run_kind_ff;
                  res.channel      = run_channel_ff;
                  res.first_data   = track_byte;
                  res.parse_status = mtep_pkg::ST_OK;
                  delta_accum_in   = '0;
                  delta_count_in   = 2'd0;
               end
            end
         end
         mtep_pkg::PH_DATA1: begin
            held_first_in = track_byte;
            if (run_length_ff == 2'd1) begin
               res_valid        = 1'b1;
               res.delta_ticks  = delta_accum_ff;
               res.event_kind   = run_kind_ff;
               res.channel      = run_channel_ff;
               res.first_data   = track_byte;
               res.parse_status = mtep_pkg::ST_OK;
               delta_accum_in   = '0;
               delta_count_in   = 2'd0;
            end
         end
         mtep_pkg::PH_DATA2: begin
            res_valid        = 1'b1;
            res.delta_ticks  = delta_accum_ff;
            res.event_kind   = run_kind_ff;
            res.channel      = run_channel_ff;
            res.first_data   = held_first_ff;
            res.second_data  = track_byte;
            res.parse_status = mtep_pkg::ST_OK;
            delta_accum_in   = '0;
            delta_count_in   = 2'd0;
            if (run_kind_ff == mtep_pkg::KIND_META && track_byte != 8'd0) begin
               skip_left_in = track_byte;
            end
         end
         mtep_pkg::PH_SKIP: begin
            skip_left_in = skip_dec;
            if (skip_dec == 8'd0) begin
               delta_accum_in = '0;
               delta_count_in = 2'd0;
            end
         end
         default: begin
            if (delta_count_ff == 2'd3 && top_set) begin
               res_valid        = 1'b1;
               res.parse_status = mtep_pkg::ST_DELTA_LONG;
               delta_accum_in   = '0;
               delta_count_in   = 2'd0;
            end else begin
               delta_accum_in = {delta_accum_ff[mtep_pkg::DELTA_WIDTH-8:0], track_byte[6:0]};
               delta_count_in = delta_count_ff + 2'd1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= mtep_pkg::PH_DELTA;
         delta_accum_ff <= '0;
         delta_count_ff <= 2'd0;
         run_kind_ff    <= 3'd0;
         run_channel_ff <= 4'd0;
         run_length_ff  <= 2'd0;
         run_valid_ff   <= 1'b0;
         held_first_ff  <= 8'd0;
         skip_left_ff   <= 8'd0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         delta_accum_ff <= delta_accum_in;
         delta_count_ff <= delta_count_in;
         run_kind_ff    <= run_kind_in;
         run_channel_ff <= run_channel_in;
         run_length_ff  <= run_length_in;
         run_valid_ff   <= run_valid_in;
         held_first_ff  <= held_first_in;
         skip_left_ff   <= skip_left_in;
      end
   end

endmodule

// ===== sv/midi_track_event_parser_top.sv =====
// ============================================================================
// midi_track_event_parser_top: MIDI track body event parser
// Takes one track byte per transaction and returns one result per event.
// ============================================================================
// A result is registered in the output register, or in the skid while rsp_stall holds it, before it reaches rsp_.
// One byte per cycle while req_stall is low; the parser updates its state on each accepted byte.
// A two-entry output buffer (output register plus skid) keeps input
// flowing while a result waits; req_stall rises only when the skid is full.
// Reset clears the parser state (delta phase, no running status) and
// empties the output buffer.
module midi_track_event_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_track_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [27:0] rsp_delta_ticks,
   output logic [2:0]  rsp_event_kind,
   output logic [3:0]  rsp_channel,
   output logic [7:0]  rsp_first_data,
   output logic [7:0]  rsp_second_data,
   output logic [1:0]  rsp_parse_status
);

   logic                 accept;
   logic                 res_valid;
   mtep_pkg::result_type res;

   logic                 out_valid_ff, out_valid_in;
   mtep_pkg::result_type out_ff, out_in;
   logic                 skid_valid_ff, skid_valid_in;
   mtep_pkg::result_type skid_ff, skid_in;
   logic                 out_free;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !out_valid_ff || !rsp_stall;

   mtep_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .track_byte (req_track_byte),
      .res_valid  (res_valid),
      .res        (res)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // no input taken while the skid holds a result
         if (out_free) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (out_free) begin
         out_valid_in = accept && res_valid;
         out_in       = res;
      end else if (accept && res_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_delta_ticks  = out_ff.delta_ticks;
   assign rsp_event_kind   = out_ff.event_kind;
   assign rsp_channel      = out_ff.channel;
   assign rsp_first_data   = out_ff.first_data;
   assign rsp_second_data  = out_ff.second_data;
   assign rsp_parse_status = out_ff.parse_status;

endmodule

// ===== sv/mtep_checker.sv =====
// ============================================================================
// mtep_checker: port-level checks of the track event parser
// Watches the result channel for hold rules and status field consistency, and the buffer state after reset.
// ============================================================================
module mtep_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [27:0] rsp_delta_ticks,
   input logic [2:0]  rsp_event_kind,
   input logic [3:0]  rsp_channel,
   input logic [7:0]  rsp_first_data,
   input logic [7:0]  rsp_second_data,
   input logic [1:0]  rsp_parse_status
);

   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result transaction dropped while stalled");

   a_rsp_hold_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_delta_ticks) && $stable(rsp_first_data)
         && $stable(rsp_second_data) && $stable(rsp_parse_status))
      else $error("stalled result payload changed");

   a_delta_long_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_parse_status == mtep_pkg::ST_DELTA_LONG |->
         rsp_delta_ticks == 28'd0 && rsp_event_kind == 3'd0 && rsp_channel == 4'd0
         && rsp_first_data == 8'd0 && rsp_second_data == 8'd0)
      else $error("delta error result carries nonzero fields");

   a_no_running_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_parse_status == mtep_pkg::ST_NO_RUNNING |->
         rsp_event_kind == 3'd0 && rsp_channel == 4'd0 && rsp_second_data == 8'd0
         && !rsp_first_data[7])
      else $error("missing running status result malformed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("output buffer not empty after reset");

endmodule

bind midi_track_event_parser_top mtep_checker u_mtep_checker (.*);
